[src/lge_pkg.sv]
// shared types and constants for the life grid engine
// no dependencies; imported by every module of the block
package lge_pkg;

  localparam int CMD_W   = 2;
  localparam int FIELD_W = 6;
  localparam int NBR_W   = 4;

  // B3/S23 neighbor counts
  localparam logic [NBR_W-1:0] BORN_COUNT    = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CELL_RD,
    S_CELL_WB,
    S_CLEAR,
    S_STEP,
    S_DONE
  } state_t;

endpackage

[src/life_grid_engine.sv]
// top level of the life grid engine: command sequencer around a row-wide grid ram
// depends on lge_pkg, lge_ram and lge_rule
//
//   channel | signals                              | notes
//   in      | in_valid in_ready command row column | one command per transfer
//           | value                                |
//   out     | out_valid out_ready cell_value       | one result per command
//
// the grid is stored one row per ram word; a step streams rows through a
// three-row window and writes each new row back in place
// transfer to result: write and read go through read, modify-write and load,
// clear and step through their row sweep and load; the next command can be taken from the cycle after the load
// after reset a clearing pass over all rows runs before the first transfer
// in_ready is high only while idle; a finished result waits in the output
// register and the next command is accepted meanwhile
module life_grid_engine
  import lge_pkg::*;
#(
  parameter int COLS = 64,
  parameter int ROWS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [FIELD_W-1:0] row,
  input  logic [FIELD_W-1:0] column,
  input  logic               value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               cell_value
);

  localparam int AW  = $clog2(ROWS);
  localparam int CW  = $clog2(ROWS + 1);
  localparam int CIW = $clog2(COLS);

  state_t state, state_next;

  logic [CW-1:0]      cnt;
  logic [CW-1:0]      rows_in;
  logic               rd_pend;
  logic [COLS-1:0]    above;
  logic [COLS-1:0]    center;
  cmd_t               cmd_q;
  logic [FIELD_W-1:0] row_q;
  logic [FIELD_W-1:0] col_q;
  logic               value_q;
  logic               inside_q;
  logic               res;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [COLS-1:0]    wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [COLS-1:0]    rd_data;

  logic [COLS-1:0]    below_sel;
  logic [COLS-1:0]    new_row;
  logic [COLS-1:0]    mod_row;
  logic [CIW-1:0]     col_idx;
  logic [CW-1:0]      rows_in_m1;
  logic               step_rd;
  logic               step_last;
  logic               sweep_end;
  logic               in_xfer;
  logic               out_load;
  logic               in_grid;

  lge_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lge_rule #(
    .COLS (COLS)
  ) u_rule (
    .above    (above),
    .center   (center),
    .below    (below_sel),
    .next_row (new_row)
  );

  assign in_xfer    = in_valid && in_ready;
  assign in_grid    = (int'(row) < ROWS) && (int'(column) < COLS);
  assign col_idx    = CIW'(col_q);
  assign rows_in_m1 = rows_in - CW'(1);
  assign step_rd    = cnt < CW'(ROWS);
  // bottom row: every read is back, so the row below is off the grid
  assign step_last  = !rd_pend && !step_rd && (rows_in == CW'(ROWS));
  assign sweep_end  = cnt == CW'(ROWS - 1);
  assign below_sel  = rd_pend ? rd_data : '0;
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    mod_row          = rd_data;
    mod_row[col_idx] = value_q;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sweep_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(command))
            CMD_CLEAR: state_next = S_CLEAR;
            CMD_STEP:  state_next = S_STEP;
            default:   state_next = S_CELL_RD;
          endcase
        end
      end
      S_CELL_RD: state_next = S_CELL_WB;
      S_CELL_WB: state_next = S_DONE;
      S_CLEAR: begin
        if (sweep_end) state_next = S_DONE;
      end
      S_STEP: begin
        if (step_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    case (state)
      S_INIT, S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[AW-1:0];
      end
      S_IDLE: in_ready = 1'b1;
      S_CELL_RD: begin
        rd_en   = 1'b1;
        rd_addr = inside_q ? AW'(row_q) : '0;
      end
      S_CELL_WB: begin
        wr_en   = (cmd_q == CMD_WRITE) && inside_q;
        wr_addr = AW'(row_q);
        wr_data = mod_row;
      end
      S_STEP: begin
        rd_en   = step_rd;
        rd_addr = cnt[AW-1:0];
        if (rd_pend && (rows_in != '0)) begin
          wr_en   = 1'b1;
          wr_addr = rows_in_m1[AW-1:0];
          wr_data = new_row;
        end else if (step_last) begin
          wr_en   = 1'b1;
          wr_addr = AW'(ROWS - 1);
          wr_data = new_row;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      rows_in   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      case (state)
        S_INIT, S_CLEAR: cnt <= cnt + CW'(1);
        S_STEP: begin
          if (step_rd) cnt <= cnt + CW'(1);
          rd_pend <= step_rd;
          if (rd_pend) rows_in <= rows_in + CW'(1);
        end
        default: ;
      endcase

      if (in_xfer) begin
        cnt     <= '0;
        rows_in <= '0;
        rd_pend <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q    <= cmd_t'(command);
      row_q    <= row;
      col_q    <= column;
      value_q  <= value;
      inside_q <= in_grid;
      res      <= 1'b0;
      // row window starts with dead rows above the grid
      above    <= '0;
      center   <= '0;
    end else begin
      if ((state == S_STEP) && rd_pend) begin
        above  <= center;
        center <= rd_data;
      end
      if ((state == S_CELL_WB) && (cmd_q == CMD_READ) && inside_q) begin
        res <= rd_data[col_idx];
      end
    end
    if (out_load) begin
      cell_value <= res;
    end
  end

endmodule

[src/lge_ram.sv]
// generic single-write, single-read ram with registered read data
// depends on lge_pkg only for the house import convention
module lge_ram
  import lge_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/lge_rule.sv]
// one row of B3/S23 cell updates from the rows above, at and below it
// depends on lge_pkg for the neighbor count constants
module lge_rule
  import lge_pkg::*;
#(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] center,
  input  logic [COLS-1:0] below,
  output logic [COLS-1:0] next_row
);

  // zero padding at both ends: nothing wraps
  logic [COLS+1:0] above_x;
  logic [COLS+1:0] center_x;
  logic [COLS+1:0] below_x;

  assign above_x  = {1'b0, above, 1'b0};
  assign center_x = {1'b0, center, 1'b0};
  assign below_x  = {1'b0, below, 1'b0};

  always_comb begin
    logic [NBR_W-1:0] n;
    for (int c = 0; c < COLS; c++) begin
      n = NBR_W'(above_x[c]) + NBR_W'(above_x[c+1]) + NBR_W'(above_x[c+2])
        + NBR_W'(center_x[c]) + NBR_W'(center_x[c+2])
        + NBR_W'(below_x[c]) + NBR_W'(below_x[c+1]) + NBR_W'(below_x[c+2]);
      next_row[c] = (n == BORN_COUNT) || (center[c] && (n == SURVIVE_COUNT));
    end
  end

endmodule
